// ===== rtl/crd_pkg.sv =====
// Shared types and constants for the cyclic reaction-diffusion cell unit.
// Used by crd_lane and cyclic_reaction_diffusion_cell_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

    // Pipeline depth: operand prep, gain/predation multiply, factor, u*factor multiply,
    // derivative add, time-step multiply, round/saturate.
    localparam int NST = 7;

    localparam logic [15:0] TIME_STEP_RST  = 16'd1092;
    localparam logic [15:0] DIFF_GAIN_RST  = 16'd8960;
    localparam logic [14:0] REACT_COEF_RST = 15'd12800;
    localparam logic [15:0] INV_RHO_RST    = 16'd1365;

    typedef enum logic [1:0] {
        REG_TIME_STEP  = 2'd0,
        REG_DIFF_GAIN  = 2'd1,
        REG_REACT_COEF = 2'd2,
        REG_INV_RHO    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] time_step;
        logic [15:0] diff_gain;
        logic [14:0] react_coef;
        logic [15:0] inv_rho;     // signed Q4.12, sign-extended where used
    } t_cfg;

    // Per-stage load enables, shared by every lane
    typedef struct packed {
        logic [NST-1:0] ld;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/cyclic_reaction_diffusion_cell_unit.sv =====
// Top level of the cyclic reaction-diffusion cell unit: stream ports, APB registers,
// pipeline valid/stall control and three species lanes. Depends on crd_pkg, crd_lane.
`timescale 1ns / 1ps
`default_nettype none

// Computes one explicit Euler step of a three-species rock-paper-scissors
// reaction-diffusion grid for one cell from the cell and its four neighbours.
// Throughput is one cell per clock while the output accepts results; cells pass
// through the seven-stage lane pipeline (laplacian, gain and predation
// multiplies, factor, u*factor multiply, derivative add, time-step multiply,
// round and saturate). Each stage holds its own valid bit, so bubbles are
// squeezed out and the input keeps flowing while a result waits, until all
// seven stages hold a request. Registers
// (APB, byte address 4*i): 0 time_step, 1 diffusion_gain, 2 reaction_coef,
// 3 inverse_rho_divisor; write them only while the pipeline is empty.

module cyclic_reaction_diffusion_cell_unit #(
    parameter int SPECIES_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // slave stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // center_cell, left_cell, right_cell, upper_cell, lower_cell (low to high)
    input  wire logic [((15*SPECIES_BITS+7)/8)*8-1:0] s_axis_tdata,
    // master stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // updated_cell
    output logic [((3*SPECIES_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // APB
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int SB    = SPECIES_BITS;
    localparam int CW    = 3 * SB;
    localparam int OUT_W = ((3*SPECIES_BITS+7)/8)*8;
    localparam int NST   = crd_pkg::NST;
    localparam int RIW   = SB + 19;

    logic [15:0]           r_time_step;
    logic [15:0]           r_diff_gain;
    logic [14:0]           r_react_coef;
    logic [15:0]           r_inv_rho;
    crd_pkg::t_cfg         w_cfg;
    crd_pkg::t_ctl         w_ctl;
    logic                  w_wr;

    logic [NST-1:0]        r_vld;
    logic [NST-1:0]        w_ld;

    logic [CW-1:0]         w_center, w_left, w_right, w_upper, w_lower;
    logic [SB+1:0]         w_rho;
    logic [SB+1:0]         r_rho0;
    logic signed [RIW-1:0] w_rinv;
    logic signed [RIW-1:0] r_rinv1;
    logic [CW-1:0]         w_res;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= crd_pkg::TIME_STEP_RST;
            r_diff_gain  <= crd_pkg::DIFF_GAIN_RST;
            r_react_coef <= crd_pkg::REACT_COEF_RST;
            r_inv_rho    <= crd_pkg::INV_RHO_RST;
        end else if (w_wr) begin
            case (crd_pkg::t_reg_idx'(paddr[3:2]))
                crd_pkg::REG_TIME_STEP:  r_time_step  <= pwdata[15:0];
                crd_pkg::REG_DIFF_GAIN:  r_diff_gain  <= pwdata[15:0];
                crd_pkg::REG_REACT_COEF: r_react_coef <= pwdata[14:0];
                crd_pkg::REG_INV_RHO:    r_inv_rho    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (crd_pkg::t_reg_idx'(paddr[3:2]))
            crd_pkg::REG_TIME_STEP:  prdata = {16'h0000, r_time_step};
            crd_pkg::REG_DIFF_GAIN:  prdata = {16'h0000, r_diff_gain};
            crd_pkg::REG_REACT_COEF: prdata = {17'd0, r_react_coef};
            crd_pkg::REG_INV_RHO:    prdata = {16'h0000, r_inv_rho};
            default:                 prdata = '0;
        endcase
    end

    assign w_cfg.time_step  = r_time_step;
    assign w_cfg.diff_gain  = r_diff_gain;
    assign w_cfg.react_coef = r_react_coef;
    assign w_cfg.inv_rho    = r_inv_rho;

    // ---------------- pipeline control ----------------
    // A stage loads when it is empty or the stage after it moves.
    always_comb begin
        w_ld[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign w_ctl.ld = w_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_ld[0];
    assign m_axis_tvalid = r_vld[NST-1];

    // ---------------- shared total density ----------------
    assign w_center = s_axis_tdata[0*CW +: CW];
    assign w_left   = s_axis_tdata[1*CW +: CW];
    assign w_right  = s_axis_tdata[2*CW +: CW];
    assign w_upper  = s_axis_tdata[3*CW +: CW];
    assign w_lower  = s_axis_tdata[4*CW +: CW];

    assign w_rho  = {2'b00, w_center[0 +: SB]} + {2'b00, w_center[SB +: SB]}
                  + {2'b00, w_center[2*SB +: SB]};
    assign w_rinv = $signed({{(RIW-SB-2){1'b0}}, r_rho0})
                  * $signed({{(RIW-16){r_inv_rho[15]}}, r_inv_rho});

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_rho0 <= w_rho;
        end
        if (w_ld[1]) begin
            r_rinv1 <= w_rinv;
        end
    end

    // ---------------- species lanes ----------------
    for (genvar g = 0; g < 3; g++) begin : g_lane
        crd_lane #(
            .SB(SB)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_cfg   (w_cfg),
            .i_u     (w_center[g*SB +: SB]),
            .i_w     (w_center[((g+1)%3)*SB +: SB]),
            .i_left  (w_left[g*SB +: SB]),
            .i_right (w_right[g*SB +: SB]),
            .i_upper (w_upper[g*SB +: SB]),
            .i_lower (w_lower[g*SB +: SB]),
            .i_rinv  (r_rinv1),
            .o_val   (w_res[g*SB +: SB])
        );
    end

    assign m_axis_tdata = OUT_W'(w_res);

    // ---------------- assertions ----------------
    // input can only stall when every stage holds a request and the output is blocked
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> ((&r_vld) && !m_axis_tready))
        else $error("input stalled with a free pipeline slot");

    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_accept_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted request not captured in first stage");

    // no request appears or vanishes inside the pipeline
    a_conserve : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
        |=> ($countones(r_vld) == $past($countones(r_vld))))
        else $error("pipeline request count changed without a handshake");

endmodule

`default_nettype wire

// ===== rtl/crd_lane.sv =====
// One species lane of the reaction-diffusion update: seven register stages.
// Depends on crd_pkg (t_cfg, t_ctl, NST).
`timescale 1ns / 1ps
`default_nettype none

module crd_lane #(
    parameter int SB = 16
) (
    input  wire logic                 i_clk,
    input  wire crd_pkg::t_ctl        i_ctl,
    input  wire crd_pkg::t_cfg        i_cfg,
    input  wire logic [SB-1:0]        i_u,
    input  wire logic [SB-1:0]        i_w,
    input  wire logic [SB-1:0]        i_left,
    input  wire logic [SB-1:0]        i_right,
    input  wire logic [SB-1:0]        i_upper,
    input  wire logic [SB-1:0]        i_lower,
    input  wire logic signed [SB+18:0] i_rinv,   // rho*inv, aligned with stage 1
    output logic [SB-1:0]             o_val
);

    localparam int LW  = SB + 3;    // laplacian
    localparam int DMW = SB + 20;   // gain*lap
    localparam int CWW = SB + 15;   // coef*w
    localparam int RIW = SB + 19;   // rho*inv
    localparam int FW  = SB + 22;   // factor
    localparam int PW  = SB + 1 + FW;
    localparam int DW  = SB + 25;   // derivative
    localparam int MW  = DW + 17;
    localparam int XW  = MW - 28;   // step delta
    localparam logic [FW-1:0] ONE  = {{(FW-1){1'b0}}, 1'b1} << (SB + 12);
    localparam logic [MW-1:0] HALF = {{(MW-1){1'b0}}, 1'b1} << 27;

    // stage 0
    logic [SB+1:0]          w_nsum;
    logic signed [LW-1:0]   w_lap;
    logic [SB-1:0]          r_u0, r_w0;
    logic signed [LW-1:0]   r_lap0;
    // stage 1
    logic signed [DMW-1:0]  w_lap_x, w_gain_x, w_dm;
    logic [CWW-1:0]         w_cw;
    logic [SB-1:0]          r_u1;
    logic signed [DMW-1:0]  r_dm1;
    logic [CWW-1:0]         r_cw1;
    // stage 2
    logic signed [FW-1:0]   w_ri_x, w_cw_x, w_fac;
    logic [SB-1:0]          r_u2;
    logic signed [DMW-1:0]  r_dm2;
    logic signed [FW-1:0]   r_fac2;
    // stage 3
    logic signed [PW-1:0]   w_u_x, w_fac_x, w_prd;
    logic [SB-1:0]          r_u3;
    logic signed [DMW-1:0]  r_dm3;
    logic signed [PW-1:0]   r_prd3;
    // stage 4
    logic signed [PW-SB-1:0] w_rct;
    logic signed [DW-1:0]   w_dif, w_rct_x, w_der;
    logic [SB-1:0]          r_u4;
    logic signed [DW-1:0]   r_der4;
    // stage 5
    logic signed [MW-1:0]   w_der_x, w_ts_x, w_mul;
    logic [SB-1:0]          r_u5;
    logic signed [MW-1:0]   r_m5;
    // stage 6
    logic signed [MW-1:0]   w_rnd;
    logic signed [XW-1:0]   w_dlt;
    logic signed [XW:0]     w_v;
    logic [SB-1:0]          w_sat;
    logic [SB-1:0]          r_out6;

    assign w_nsum = {2'b00, i_left} + {2'b00, i_right} + {2'b00, i_upper} + {2'b00, i_lower};
    assign w_lap  = $signed({1'b0, w_nsum}) - $signed({1'b0, i_u, 2'b00});

    assign w_lap_x  = {{(DMW-LW){r_lap0[LW-1]}}, r_lap0};
    assign w_gain_x = {{(DMW-16){1'b0}}, i_cfg.diff_gain};
    assign w_dm     = w_lap_x * w_gain_x;
    assign w_cw     = {{SB{1'b0}}, i_cfg.react_coef} * {{15{1'b0}}, r_w0};

    assign w_ri_x = {{(FW-RIW){i_rinv[RIW-1]}}, i_rinv};
    assign w_cw_x = {{(FW-CWW-4){1'b0}}, r_cw1, 4'b0000};
    assign w_fac  = ONE - w_ri_x - w_cw_x;

    assign w_u_x   = {{(PW-SB){1'b0}}, r_u2};
    assign w_fac_x = {{(PW-FW){r_fac2[FW-1]}}, r_fac2};
    assign w_prd   = w_u_x * w_fac_x;

    // floor(u*factor / 2^SB) is just the upper bits of the signed product
    assign w_rct   = r_prd3[PW-1:SB];
    assign w_dif   = {{(DW-DMW-4){r_dm3[DMW-1]}}, r_dm3, 4'b0000};
    assign w_rct_x = {{(DW-(PW-SB)){w_rct[PW-SB-1]}}, w_rct};
    assign w_der   = w_dif + w_rct_x;

    assign w_der_x = {{(MW-DW){r_der4[DW-1]}}, r_der4};
    assign w_ts_x  = {{(MW-16){1'b0}}, i_cfg.time_step};
    assign w_mul   = w_der_x * w_ts_x;

    // round half up, then saturate to [0, 2^SB-1]
    assign w_rnd = r_m5 + HALF;
    assign w_dlt = w_rnd[MW-1:28];
    assign w_v   = {w_dlt[XW-1], w_dlt} + {{(XW+1-SB){1'b0}}, r_u5};

    always_comb begin
        if (w_v[XW]) begin
            w_sat = '0;
        end else if (|w_v[XW-1:SB]) begin
            w_sat = '1;
        end else begin
            w_sat = w_v[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_u0   <= i_u;
            r_w0   <= i_w;
            r_lap0 <= w_lap;
        end
        if (i_ctl.ld[1]) begin
            r_u1  <= r_u0;
            r_dm1 <= w_dm;
            r_cw1 <= w_cw;
        end
        if (i_ctl.ld[2]) begin
            r_u2   <= r_u1;
            r_dm2  <= r_dm1;
            r_fac2 <= w_fac;
        end
        if (i_ctl.ld[3]) begin
            r_u3   <= r_u2;
            r_dm3  <= r_dm2;
            r_prd3 <= w_prd;
        end
        if (i_ctl.ld[4]) begin
            r_u4   <= r_u3;
            r_der4 <= w_der;
        end
        if (i_ctl.ld[5]) begin
            r_u5 <= r_u4;
            r_m5 <= w_mul;
        end
        if (i_ctl.ld[6]) begin
            r_out6 <= w_sat;
        end
    end

    assign o_val = r_out6;

endmodule

`default_nettype wire
